### rtl/sbd_pkg.sv
// sbd_pkg: shared constants, tables, state types and helper functions
// for the split-band de-esser. No dependencies; imported by split_band_deesser_unit and sbd_gain_unit.
package sbd_pkg;

    localparam int unsigned MAX_STAGES = 4;

    localparam logic [23:0] ONE_Q23    = 24'd8388608;
    localparam logic [23:0] NEAR_UNITY = 24'd8387769;
    localparam logic [23:0] ENV_FLOOR  = 24'd8;

    // 1/256 dB per octave (Q16) and octaves per 1/256 dB (Q32)
    localparam logic signed [27:0] DB256_PER_OCT = 28'sd101008905;
    localparam logic [21:0]        OCT_PER_DB256 = 22'd2786635;

    // 2^(-2^-k) in Q30, k = 1..12
    localparam logic [29:0] POW2_NEG_Q30 [12] = '{
        30'd759250125,  30'd902905651,  30'd984625594,  30'd1028218693,
        30'd1050733751, 30'd1062175491, 30'd1067954479, 30'd1070838486,
        30'd1072289172, 30'd1073015252, 30'd1073378436, 30'd1073560135
    };

    // configuration register indexes
    localparam logic [2:0] REG_COEF_B0   = 3'd0;
    localparam logic [2:0] REG_COEF_A1   = 3'd1;
    localparam logic [2:0] REG_COEF_A2   = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_AMOUNT    = 3'd4;
    localparam logic [2:0] REG_ATTACK    = 3'd5;
    localparam logic [2:0] REG_RELEASE   = 3'd6;
    localparam logic [2:0] REG_CONTROL   = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_MUL_B, ST_Y, ST_MUL_A1, ST_MUL_A2, ST_WR,
        ST_ENV_MUL, ST_ENV, ST_GAIN, ST_OUT_L, ST_OUT_R, ST_DONE
    } ctl_state_t;

    typedef enum logic [2:0] {
        G_IDLE, G_NORM, G_LOG, G_DB, G_CURVE, G_OCT, G_EXP, G_FIN
    } gain_state_t;

    typedef struct packed {
        logic              start;
        logic [23:0]       env;
        logic [14:0]       threshold;
        logic [13:0]       amount;
    } gain_req_t;

    typedef struct packed {
        logic              done;
        logic signed [13:0] gain;
        logic [23:0]       glin;
    } gain_rsp_t;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [23:0] mag24(input logic signed [23:0] v);
        logic signed [24:0] w;
        w = 25'(v);
        if (w < 0)
            w = -w;
        return w[23:0];
    endfunction

endpackage

### rtl/split_band_deesser_unit.sv
// split_band_deesser_unit: top level; sequencer, stage datapath, envelope and output.
// Uses sbd_pkg, sbd_delay_mem and sbd_gain_unit.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata 48b, s_tuser 1b
//  m_       out  m_tvalid/m_tready    m_tdata 112b
//  cfg_     in   cfg_valid/cfg_ready  cfg_index 3b, cfg_data 32b
//
// Each frame runs, per biquad stage per channel, a read, three multiplies through
// one shared multiplier and a write-back; then with reduction enabled an envelope
// update and the gain unit, a left and a right mix step when the band is cut,
// and the load of the output register.
// The next beat can be taken in the cycle after the result loads.
// Registers are written only idle.
// Reset is synchronous; delay store and envelope read zero afterwards.
// Results sit in an output register, so a stalled m_ side holds only the final beat.
module split_band_deesser_unit
    import sbd_pkg::*;
#(
    parameter int unsigned MaxStages = MAX_STAGES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // sample_left[23:0], sample_right[47:24]
    input  logic [0:0]   s_tuser,   // stereo[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // out_left, out_right, input_level,
                                    // sidechain_level, gain_reduction_db[109:96]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int unsigned Depth = 2 * MaxStages;
    localparam int unsigned AW    = $clog2(Depth);

    // configuration
    logic signed [31:0] b0_reg, a1_reg, a2_reg;
    logic [14:0]        thr_reg;
    logic [13:0]        amt_reg;
    logic [23:0]        atk_reg, rel_reg;
    logic [2:0]         ctrl_reg;

    ctl_state_t state_reg, state_next;

    logic               chan_reg;
    logic [1:0]         stage_reg;
    logic               apply_reg;
    logic [23:0]        env_reg;
    logic               m_tvalid_reg;
    logic [111:0]       m_tdata_reg;

    logic signed [23:0] l_reg, r_reg, x_reg, y_reg, bl_reg, br_reg, outl_reg;
    logic               stereo_reg;
    logic [23:0]        inlvl_reg;
    logic signed [31:0] d1_reg, d2_reg, z1_reg;
    logic signed [56:0] bx_reg, prod_reg;
    logic signed [13:0] gain_reg;
    logic [23:0]        glin_reg;

    logic               mul_en, mem_rd_en, mem_wr_en, load_out, out_free;
    logic signed [31:0] mul_a;
    logic signed [24:0] mul_b;
    logic [AW-1:0]      mem_addr;
    logic [63:0]        mem_rd_data;
    logic [2:0]         stage_cnt;
    logic               last_stage;

    logic signed [23:0] in_l, in_r;
    logic [23:0]        in_lvl, sc;
    logic signed [61:0] ysum, z1sum, z2sum;
    logic signed [23:0] y_next;
    logic signed [31:0] z1_next, z2_next;
    logic [23:0]        k_sel;
    logic signed [24:0] env_diff, delta;
    logic signed [57:0] env_step, band_adj;
    logic signed [26:0] env_sum;
    logic [23:0]        env_next;
    logic signed [23:0] outl_next, outr_next;
    logic               apply_now;

    gain_req_t gain_req;
    gain_rsp_t gain_rsp;

    // a waiting frame goes first; registers change only between frames
    assign cfg_ready = (state_reg == ST_IDLE) && !s_tvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg   <= '0;
            a1_reg   <= '0;
            a2_reg   <= '0;
            thr_reg  <= 15'h6C00;
            amt_reg  <= 14'h3A00;
            atk_reg  <= ONE_Q23;
            rel_reg  <= ONE_Q23;
            ctrl_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_COEF_B0:   b0_reg   <= cfg_data;
                REG_COEF_A1:   a1_reg   <= cfg_data;
                REG_COEF_A2:   a2_reg   <= cfg_data;
                REG_THRESHOLD: thr_reg  <= cfg_data[14:0];
                REG_AMOUNT:    amt_reg  <= cfg_data[13:0];
                REG_ATTACK:    atk_reg  <= cfg_data[23:0];
                REG_RELEASE:   rel_reg  <= cfg_data[23:0];
                REG_CONTROL:   ctrl_reg <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    // stage count, limited to MaxStages
    always_comb begin
        stage_cnt = {1'b0, ctrl_reg[1:0]} + 3'd1;
        if ({1'b0, stage_cnt} > 4'(MaxStages))
            stage_cnt = 3'(MaxStages);
    end
    assign last_stage = (({1'b0, stage_reg} + 3'd1) == stage_cnt);
    assign mem_addr   = chan_reg ? AW'(MaxStages) + AW'(stage_reg) : AW'(stage_reg);

    assign in_l   = s_tdata[23:0];
    assign in_r   = s_tuser[0] ? s_tdata[47:24] : s_tdata[23:0];
    assign in_lvl = (mag24(in_l) > mag24(in_r)) ? mag24(in_l) : mag24(in_r);
    assign sc     = (mag24(bl_reg) > mag24(br_reg)) ? mag24(bl_reg) : mag24(br_reg);

    // biquad arithmetic, rounding is add-half then floor
    assign ysum    = 62'(prod_reg) + (62'(d1_reg) <<< 28) + (62'sd1 <<< 27);
    assign y_next  = sat24(64'(ysum >>> 28));
    assign z1sum   = (62'(d2_reg) <<< 28) - 62'(prod_reg) + (62'sd1 <<< 27);
    assign z1_next = sat32(64'(z1sum >>> 28));
    assign z2sum   = -62'(bx_reg) - 62'(prod_reg) + (62'sd1 <<< 27);
    assign z2_next = sat32(64'(z2sum >>> 28));

    // envelope
    always_comb begin
        k_sel = (sc > env_reg) ? atk_reg : rel_reg;
        if (k_sel > ONE_Q23)
            k_sel = ONE_Q23;
    end
    assign env_diff = $signed({1'b0, sc}) - $signed({1'b0, env_reg});
    assign env_step = (58'(prod_reg) + (58'sd1 <<< 22)) >>> 23;
    assign env_sum  = $signed({3'b000, env_reg}) + 27'(env_step);
    always_comb begin
        if (env_sum < 0)
            env_next = '0;
        else if (env_sum > $signed({3'b000, ONE_Q23}))
            env_next = ONE_Q23;
        else
            env_next = env_sum[23:0];
    end

    // output mix
    assign delta     = $signed({1'b0, glin_reg}) - $signed({1'b0, ONE_Q23});
    assign band_adj  = (58'(prod_reg) + (58'sd1 <<< 22)) >>> 23;
    assign outl_next = sat24(64'(l_reg) + 64'(band_adj));
    always_comb begin
        if (!stereo_reg)
            outr_next = outl_reg;
        else if (apply_reg)
            outr_next = sat24(64'(r_reg) + 64'(band_adj));
        else
            outr_next = r_reg;
    end
    assign apply_now = (gain_rsp.gain < 0) && (gain_rsp.glin < NEAR_UNITY);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_rd_en  = 1'b0;
        mem_wr_en  = 1'b0;
        mul_en     = 1'b0;
        load_out   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_RD;
            end
            ST_RD: begin
                mem_rd_en  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                mul_en     = 1'b1;
                mul_a      = b0_reg;
                mul_b      = 25'(x_reg);
                state_next = ST_Y;
            end
            ST_Y: state_next = ST_MUL_A1;
            ST_MUL_A1: begin
                mul_en     = 1'b1;
                mul_a      = a1_reg;
                mul_b      = 25'(y_reg);
                state_next = ST_MUL_A2;
            end
            ST_MUL_A2: begin
                mul_en     = 1'b1;
                mul_a      = a2_reg;
                mul_b      = 25'(y_reg);
                state_next = ST_WR;
            end
            ST_WR: begin
                mem_wr_en = 1'b1;
                if (!last_stage || (!chan_reg && stereo_reg))
                    state_next = ST_RD;
                else if (ctrl_reg[2])
                    state_next = ST_ENV_MUL;
                else
                    state_next = ST_DONE;
            end
            ST_ENV_MUL: begin
                mul_en     = 1'b1;
                mul_a      = $signed(32'(k_sel));
                mul_b      = env_diff;
                state_next = ST_ENV;
            end
            ST_ENV: state_next = ST_GAIN;
            ST_GAIN: begin
                if (gain_rsp.done)
                    state_next = apply_now ? ST_OUT_L : ST_DONE;
            end
            ST_OUT_L: begin
                mul_en     = 1'b1;
                mul_a      = 32'(bl_reg);
                mul_b      = delta;
                state_next = ST_OUT_R;
            end
            ST_OUT_R: begin
                mul_en     = 1'b1;
                mul_a      = 32'(br_reg);
                mul_b      = delta;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg     <= 1'b0;
            stage_reg    <= '0;
            apply_reg    <= 1'b0;
            env_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_IDLE && s_tvalid) begin
                chan_reg  <= 1'b0;
                stage_reg <= '0;
            end
            if (state_reg == ST_WR) begin
                apply_reg <= 1'b0;
                if (!last_stage) begin
                    stage_reg <= stage_reg + 2'd1;
                end else if (!chan_reg && stereo_reg) begin
                    chan_reg  <= 1'b1;
                    stage_reg <= '0;
                end
            end
            if (state_reg == ST_ENV)
                env_reg <= env_next;
            if (state_reg == ST_GAIN && gain_rsp.done)
                apply_reg <= apply_now;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
        if (load_out)
            m_tdata_reg <= {2'b00, gain_reg, sc, inlvl_reg, outr_next, outl_reg};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    l_reg      <= in_l;
                    r_reg      <= in_r;
                    x_reg      <= in_l;
                    stereo_reg <= s_tuser[0];
                    inlvl_reg  <= in_lvl;
                end
            end
            ST_MUL_B: begin
                d1_reg <= mem_rd_data[63:32];
                d2_reg <= mem_rd_data[31:0];
            end
            ST_Y: begin
                y_reg  <= y_next;
                bx_reg <= prod_reg;
            end
            ST_MUL_A2: z1_reg <= z1_next;
            ST_WR: begin
                gain_reg <= '0;
                outl_reg <= l_reg;
                // right channel starts from its own input after the left cascade
                if (last_stage && !chan_reg && stereo_reg)
                    x_reg <= r_reg;
                else
                    x_reg <= y_reg;
                if (last_stage) begin
                    if (!chan_reg) begin
                        bl_reg <= y_reg;
                        br_reg <= y_reg;
                    end else begin
                        br_reg <= y_reg;
                    end
                end
            end
            ST_GAIN: begin
                if (gain_rsp.done) begin
                    gain_reg <= gain_rsp.gain;
                    glin_reg <= gain_rsp.glin;
                end
            end
            ST_OUT_R: outl_reg <= outl_next;
            default:  ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign gain_req.start     = (state_reg == ST_ENV);
    assign gain_req.env       = env_next;
    assign gain_req.threshold = thr_reg;
    assign gain_req.amount    = amt_reg;

    sbd_delay_mem #(
        .Depth (Depth),
        .AddrW (AW),
        .DataW (64)
    ) u_delay_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data ({z1_reg, z2_next})
    );

    sbd_gain_unit u_gain_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (gain_req),
        .rsp     (gain_rsp)
    );

`ifndef SYNTHESIS
    a_gain_done_when_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_rsp.done |-> state_reg == ST_GAIN)
        else $error("gain unit finished outside the wait state");

    a_env_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg <= ONE_Q23)
        else $error("envelope above unity");

    a_wr_addr_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> 32'(mem_addr) < Depth)
        else $error("delay write beyond store");

    a_one_frame_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second frame taken while busy");
`endif

endmodule

### rtl/sbd_delay_mem.sv
// sbd_delay_mem: filter delay store, one word {z1, z2} per stage and channel.
// Synchronous write, registered read; per-entry valid bits make unwritten entries read zero.
module sbd_delay_mem #(
    parameter int unsigned Depth = 8,
    parameter int unsigned AddrW = $clog2(Depth),
    parameter int unsigned DataW = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [DataW-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [DataW-1:0] wr_data
);

    logic [DataW-1:0] mem [Depth];
    logic [Depth-1:0] valid_reg;
    logic [DataW-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/sbd_gain_unit.sv
// sbd_gain_unit: envelope to dB (log2 by repeated squaring), reduction curve,
// and dB to linear gain (table of 2^-2^-k factors). Depends on sbd_pkg.
module sbd_gain_unit
    import sbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  gain_req_t req,
    output gain_rsp_t rsp
);

    gain_state_t gstate_reg, gstate_next;

    logic [23:0]        env_reg;
    logic [4:0]         p_reg;
    logic [23:0]        m_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         it_reg;
    logic signed [49:0] dbp_reg;
    logic signed [13:0] gain_reg;
    logic [18:0]        t_reg;
    logic [30:0]        g_reg;
    logic [3:0]         k_reg;

    logic [23:0]        env_c;
    logic [4:0]         lead;
    logic [47:0]        sq;
    logic [24:0]        ms;
    logic signed [5:0]  oct_int;
    logic signed [21:0] lg;
    logic signed [49:0] db_rnd;
    logic signed [26:0] excess;
    logic signed [28:0] red;
    logic signed [28:0] amount_c;
    logic signed [13:0] gain_next;
    logic [34:0]        t_prod;
    logic [60:0]        g_prod;
    logic [11:0]        part;
    logic [30:0]        g_shift;

    always_comb begin
        env_c = env_reg;
        if (env_c < ENV_FLOOR)
            env_c = ENV_FLOOR;
        else if (env_c > ONE_Q23)
            env_c = ONE_Q23;
        lead = '0;
        for (int i = 0; i < 24; i++)
            if (env_c[i])
                lead = 5'(i);
    end

    assign sq      = 48'(m_reg) * 48'(m_reg);
    assign ms      = sq[47:23];
    assign oct_int = $signed({1'b0, p_reg}) - 6'sd23;
    assign lg      = $signed({oct_int, frac_reg});
    assign db_rnd  = (dbp_reg + (50'sd1 <<< 23)) >>> 24;
    assign excess  = 27'(db_rnd) - 27'($signed(req.threshold));

    always_comb begin
        amount_c = 29'($signed(req.amount));
        if (amount_c > 0)
            amount_c = '0;
        else if (amount_c < -29'sd6144)
            amount_c = -29'sd6144;
        red = '0;
        if (excess > 0) begin
            red = -((29'(excess) * 29'sd3 + 29'sd2) >>> 2);
            if (red < amount_c)
                red = amount_c;
        end
        gain_next = 14'(red);
    end

    // cut magnitude is at most 6144, zero-extended before the multiply
    assign t_prod  = (35'($unsigned(-gain_reg)) * 35'(OCT_PER_DB256) + 35'd32768) >> 16;
    assign part    = t_reg[15:4];
    assign g_prod  = 61'(g_reg) * 61'(POW2_NEG_Q30[k_reg]) + (61'd1 << 29);
    assign g_shift = g_reg >> t_reg[18:16];

    always_ff @(posedge aclk) begin
        if (!aresetn)
            gstate_reg <= G_IDLE;
        else
            gstate_reg <= gstate_next;
    end

    always_comb begin
        gstate_next = gstate_reg;
        unique case (gstate_reg)
            G_IDLE:  if (req.start) gstate_next = G_NORM;
            G_NORM:  gstate_next = G_LOG;
            G_LOG:   if (it_reg == 4'd15) gstate_next = G_DB;
            G_DB:    gstate_next = G_CURVE;
            G_CURVE: gstate_next = (gain_next < 0) ? G_OCT : G_FIN;
            G_OCT:   gstate_next = G_EXP;
            G_EXP:   if (k_reg == 4'd11) gstate_next = G_FIN;
            G_FIN:   gstate_next = G_IDLE;
            default: gstate_next = G_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (gstate_reg)
            G_IDLE: if (req.start) env_reg <= req.env;
            G_NORM: begin
                p_reg    <= lead;
                m_reg    <= 24'(env_c << (5'd23 - lead));
                frac_reg <= '0;
                it_reg   <= '0;
            end
            G_LOG: begin
                m_reg    <= ms[24] ? ms[24:1] : ms[23:0];
                frac_reg <= {frac_reg[14:0], ms[24]};
                it_reg   <= it_reg + 4'd1;
            end
            G_DB:    dbp_reg <= 50'(lg) * 50'(DB256_PER_OCT);
            G_CURVE: begin
                gain_reg <= gain_next;
                g_reg    <= 31'd1 << 30;
                t_reg    <= '0;
            end
            G_OCT: begin
                t_reg <= 19'(t_prod);
                k_reg <= '0;
            end
            G_EXP: begin
                if (part[4'd11 - k_reg])
                    g_reg <= 31'(g_prod >> 30);
                k_reg <= k_reg + 4'd1;
            end
            G_FIN:   ;
            default: ;
        endcase
    end

    assign rsp.done = (gstate_reg == G_FIN);
    assign rsp.gain = gain_reg;
    assign rsp.glin = 24'((g_shift + 31'd64) >> 7);

endmodule
